>>> hdl/avs_pkg.sv
// Shared types and constants for the A/V sync clock block.
// No dependencies; used by the top level, avs_core and avs_checker.
package avs_pkg;

    localparam int DROP_THR_W = 24;
    localparam int DISC_THR_W = 28;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;
    localparam int DEC_W      = 2;

    localparam logic [DROP_THR_W-1:0] DROP_THR_RESET = 24'd100_000;
    localparam logic [DISC_THR_W-1:0] DISC_THR_RESET = 28'd5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_THR = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_AUDIO = 2'd0,
        CMD_VIDEO = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [DEC_W-1:0] {
        DEC_NONE   = 2'd0,
        DEC_RENDER = 2'd1,
        DEC_DROP   = 2'd2
    } t_decision;

endpackage

>>> hdl/av_sync_frame_drop_clock.sv
// Audio-master A/V sync clock with video frame drop decision, top level.
// Depends on avs_pkg and avs_core.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command beat: an audio
//   stamp, a video frame check or a timing reset, each with the current
//   wall time. Output channel (o_valid / i_ready) returns one result beat
//   per command: frame decision, anchor flags, playback clock, counters
//   and the video minus audio difference.
//   A beat goes through the input register, then the state update and
//   result capture in the output register. Throughput is one beat per
//   cycle unless the receiver stalls; the state update between the two
//   registers sets that figure. Threshold registers are written through
//   i_cfg_wr_en / i_cfg_index / i_cfg_wr_data; the user writes them only
//   while no beat is in flight, which the block does not enforce. Unknown
//   indexes are ignored. Reset clears all timing state and counters and
//   loads the default thresholds (100 ms drop, 5 s discontinuity). When
//   the receiver stalls, the result holds in the output register and one
//   more beat waits in the input register before o_ready falls.
module av_sync_frame_drop_clock #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [avs_pkg::CMD_W-1:0]          i_command,
    input  logic [TIME_BITS-1:0]               i_stamp_us,
    input  logic [TIME_BITS-1:0]               i_wall_time_us,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [avs_pkg::DEC_W-1:0]          o_decision,
    output logic                               o_reanchored,
    output logic                               o_is_anchored,
    output logic [TIME_BITS-1:0]               o_clock_us,
    output logic [COUNT_BITS-1:0]              o_dropped_total,
    output logic [COUNT_BITS-1:0]              o_rendered_total,
    output logic [COUNT_BITS-1:0]              o_audio_total,
    output logic signed [TIME_BITS:0]          o_av_diff_us,
    input  logic                               i_cfg_wr_en,
    input  logic [avs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [avs_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);

    logic [avs_pkg::DROP_THR_W-1:0] r_drop_thr;
    logic [avs_pkg::DISC_THR_W-1:0] r_disc_thr;

    logic                      r_in_valid;
    logic [avs_pkg::CMD_W-1:0] r_command;
    logic [TIME_BITS-1:0]      r_stamp;
    logic [TIME_BITS-1:0]      r_wall;

    logic                      r_out_valid;
    avs_pkg::t_decision        r_decision;
    logic                      r_reanchored;
    logic                      r_is_anchored;
    logic [TIME_BITS-1:0]      r_clock;
    logic [COUNT_BITS-1:0]     r_dropped;
    logic [COUNT_BITS-1:0]     r_rendered;
    logic [COUNT_BITS-1:0]     r_audio;
    logic signed [TIME_BITS:0] r_av_diff;

    logic                      advance;
    logic                      in_accept;
    avs_pkg::t_decision        res_decision;
    logic                      res_reanchored;
    logic                      res_is_anchored;
    logic [TIME_BITS-1:0]      res_clock;
    logic [COUNT_BITS-1:0]     res_dropped;
    logic [COUNT_BITS-1:0]     res_rendered;
    logic [COUNT_BITS-1:0]     res_audio;
    logic signed [TIME_BITS:0] res_av_diff;

    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_thr <= avs_pkg::DROP_THR_RESET;
            r_disc_thr <= avs_pkg::DISC_THR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                avs_pkg::CFG_DROP_THR: r_drop_thr <= i_cfg_wr_data[avs_pkg::DROP_THR_W-1:0];
                avs_pkg::CFG_DISC_THR: r_disc_thr <= i_cfg_wr_data[avs_pkg::DISC_THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= i_command;
            r_stamp   <= i_stamp_us;
            r_wall    <= i_wall_time_us;
        end
    end

    avs_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_command     (r_command),
        .i_stamp       (r_stamp),
        .i_wall        (r_wall),
        .i_drop_thr    (r_drop_thr),
        .i_disc_thr    (r_disc_thr),
        .o_decision    (res_decision),
        .o_reanchored  (res_reanchored),
        .o_is_anchored (res_is_anchored),
        .o_clock       (res_clock),
        .o_dropped     (res_dropped),
        .o_rendered    (res_rendered),
        .o_audio       (res_audio),
        .o_av_diff     (res_av_diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_decision    <= res_decision;
            r_reanchored  <= res_reanchored;
            r_is_anchored <= res_is_anchored;
            r_clock       <= res_clock;
            r_dropped     <= res_dropped;
            r_rendered    <= res_rendered;
            r_audio       <= res_audio;
            r_av_diff     <= res_av_diff;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_decision       = r_decision;
    assign o_reanchored     = r_reanchored;
    assign o_is_anchored    = r_is_anchored;
    assign o_clock_us       = r_clock;
    assign o_dropped_total  = r_dropped;
    assign o_rendered_total = r_rendered;
    assign o_audio_total    = r_audio;
    assign o_av_diff_us     = r_av_diff;

endmodule

>>> hdl/avs_clock.sv
// Playback clock evaluation: anchor stamp plus elapsed wall time, saturating; zero while unanchored.
// Depends on nothing; instantiated by avs_core.
module avs_clock #(
    parameter int TIME_BITS = 48
) (
    input  logic                 i_anchored,
    input  logic [TIME_BITS-1:0] i_anchor_pts,
    input  logic [TIME_BITS-1:0] i_anchor_wall,
    input  logic [TIME_BITS-1:0] i_wall,
    output logic [TIME_BITS-1:0] o_clock
);

    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS:0]   sum;

    assign elapsed = i_wall - i_anchor_wall;
    assign sum     = {1'b0, i_anchor_pts} + {1'b0, elapsed};

    always_comb begin
        if (!i_anchored) begin
            o_clock = '0;
        end else if (i_wall < i_anchor_wall) begin
            o_clock = i_anchor_pts;
        end else if (sum[TIME_BITS]) begin
            o_clock = '1;
        end else begin
            o_clock = sum[TIME_BITS-1:0];
        end
    end

endmodule

>>> hdl/avs_core.sv
// Sync state, frame decision and counters for one beat per cycle while i_fire is high.
// Depends on avs_pkg and avs_clock.
module avs_core #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic [avs_pkg::CMD_W-1:0]          i_command,
    input  logic [TIME_BITS-1:0]               i_stamp,
    input  logic [TIME_BITS-1:0]               i_wall,
    input  logic [avs_pkg::DROP_THR_W-1:0]     i_drop_thr,
    input  logic [avs_pkg::DISC_THR_W-1:0]     i_disc_thr,
    output avs_pkg::t_decision                 o_decision,
    output logic                               o_reanchored,
    output logic                               o_is_anchored,
    output logic [TIME_BITS-1:0]               o_clock,
    output logic [COUNT_BITS-1:0]              o_dropped,
    output logic [COUNT_BITS-1:0]              o_rendered,
    output logic [COUNT_BITS-1:0]              o_audio,
    output logic signed [TIME_BITS:0]          o_av_diff
);

    logic                  r_anchored,    n_anchored;
    logic [TIME_BITS-1:0]  r_anchor_pts,  n_anchor_pts;
    logic [TIME_BITS-1:0]  r_anchor_wall, n_anchor_wall;
    logic [TIME_BITS-1:0]  r_last_audio,  n_last_audio;
    logic [TIME_BITS-1:0]  r_last_video,  n_last_video;
    logic [COUNT_BITS-1:0] r_dropped,     n_dropped;
    logic [COUNT_BITS-1:0] r_rendered,    n_rendered;
    logic [COUNT_BITS-1:0] r_audio,       n_audio;

    logic [TIME_BITS-1:0]  clk_now;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS-1:0]  late;
    logic [TIME_BITS-1:0]  disc_thr;
    logic [TIME_BITS-1:0]  drop_thr;

    avs_clock #(
        .TIME_BITS (TIME_BITS)
    ) u_clock (
        .i_anchored    (r_anchored),
        .i_anchor_pts  (r_anchor_pts),
        .i_anchor_wall (r_anchor_wall),
        .i_wall        (i_wall),
        .o_clock       (clk_now)
    );

    assign disc_thr = {{(TIME_BITS-avs_pkg::DISC_THR_W){1'b0}}, i_disc_thr};
    assign drop_thr = {{(TIME_BITS-avs_pkg::DROP_THR_W){1'b0}}, i_drop_thr};
    assign gap      = (i_stamp >= clk_now) ? (i_stamp - clk_now) : (clk_now - i_stamp);
    assign late     = clk_now - i_stamp;

    always_comb begin
        n_anchored    = r_anchored;
        n_anchor_pts  = r_anchor_pts;
        n_anchor_wall = r_anchor_wall;
        n_last_audio  = r_last_audio;
        n_last_video  = r_last_video;
        n_dropped     = r_dropped;
        n_rendered    = r_rendered;
        n_audio       = r_audio;
        o_decision    = avs_pkg::DEC_NONE;
        o_reanchored  = 1'b0;
        case (avs_pkg::t_cmd'(i_command))
            avs_pkg::CMD_AUDIO: begin
                if (i_stamp != '0) begin
                    n_audio      = r_audio + 1'b1;
                    n_last_audio = i_stamp;
                    if (!r_anchored || gap > disc_thr) begin
                        n_anchored    = 1'b1;
                        n_anchor_pts  = i_stamp;
                        n_anchor_wall = i_wall;
                        o_reanchored  = 1'b1;
                    end
                end
            end
            avs_pkg::CMD_VIDEO: begin
                n_last_video = i_stamp;
                if (r_anchored && clk_now > i_stamp && late > drop_thr) begin
                    n_dropped  = r_dropped + 1'b1;
                    o_decision = avs_pkg::DEC_DROP;
                end else begin
                    n_rendered = r_rendered + 1'b1;
                    o_decision = avs_pkg::DEC_RENDER;
                end
            end
            avs_pkg::CMD_RESET: begin
                n_anchored    = 1'b0;
                n_anchor_pts  = '0;
                n_anchor_wall = '0;
                n_last_audio  = '0;
                n_last_video  = '0;
                n_dropped     = '0;
                n_rendered    = '0;
                n_audio       = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_is_anchored = n_anchored;
        o_dropped     = n_dropped;
        o_rendered    = n_rendered;
        o_audio       = n_audio;
        if (o_reanchored) begin
            o_clock = i_stamp;
        end else if (n_anchored) begin
            o_clock = clk_now;
        end else begin
            o_clock = '0;
        end
        if (n_anchored && n_last_video != '0 && n_last_audio != '0) begin
            o_av_diff = {1'b0, n_last_video} - {1'b0, n_last_audio};
        end else begin
            o_av_diff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchored    <= 1'b0;
            r_anchor_pts  <= '0;
            r_anchor_wall <= '0;
            r_last_audio  <= '0;
            r_last_video  <= '0;
            r_dropped     <= '0;
            r_rendered    <= '0;
            r_audio       <= '0;
        end else if (i_fire) begin
            r_anchored    <= n_anchored;
            r_anchor_pts  <= n_anchor_pts;
            r_anchor_wall <= n_anchor_wall;
            r_last_audio  <= n_last_audio;
            r_last_video  <= n_last_video;
            r_dropped     <= n_dropped;
            r_rendered    <= n_rendered;
            r_audio       <= n_audio;
        end
    end

endmodule

>>> hdl/avs_checker.sv
// Port-level checks for av_sync_frame_drop_clock, attached by bind.
// Depends on avs_pkg and the top level's port list.
module avs_checker #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic [avs_pkg::CMD_W-1:0]          i_command,
    input logic [TIME_BITS-1:0]               i_stamp_us,
    input logic [TIME_BITS-1:0]               i_wall_time_us,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [avs_pkg::DEC_W-1:0]          o_decision,
    input logic                               o_reanchored,
    input logic                               o_is_anchored,
    input logic [TIME_BITS-1:0]               o_clock_us,
    input logic [COUNT_BITS-1:0]              o_dropped_total,
    input logic [COUNT_BITS-1:0]              o_rendered_total,
    input logic [COUNT_BITS-1:0]              o_audio_total,
    input logic signed [TIME_BITS:0]          o_av_diff_us,
    input logic                               i_cfg_wr_en,
    input logic [avs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [avs_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_clock_us) && $stable(o_decision))
        else $error("output beat changed while stalled");

    a_unanchored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_anchored |-> o_clock_us == '0 && o_av_diff_us == '0)
        else $error("clock or difference nonzero without anchor");

    a_reanchor_audio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reanchored |-> o_is_anchored && o_decision == avs_pkg::DEC_NONE)
        else $error("anchor set by a beat that is not an audio stamp");

    a_drop_anchored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_decision == avs_pkg::DEC_DROP |-> o_is_anchored)
        else $error("frame dropped without anchor");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output register");

endmodule

bind av_sync_frame_drop_clock avs_checker #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_avs_checker (.*);
